### hw/rtl/gss_pkg.sv
// gss_pkg: shared types and constants of the gini split search block
// configuration record, controller-to-datapath commands and datapath status
// no dependencies
package gss_pkg;

    // configuration register indexes (byte address is 8 times the index)
    localparam logic [2:0] REG_SAMPLE_COUNT    = 3'd0;
    localparam logic [2:0] REG_PARENT_IMPURITY = 3'd1;
    localparam logic [2:0] REG_START_BEST_GAIN = 3'd2;
    localparam logic [2:0] REG_START_NUM_BEST  = 3'd3;
    localparam logic [2:0] REG_MAX_BEST        = 3'd4;
    localparam logic [2:0] REG_FEATURE_INDEX   = 3'd5;

    localparam logic signed [39:0] GAIN_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] GAIN_MIN = 40'sh80_0000_0000;

    typedef struct packed {
        logic [15:0]        sample_count;
        logic [31:0]        parent_impurity;
        logic signed [39:0] start_best_gain;
        logic [4:0]         start_num_best;
        logic [4:0]         max_best;
        logic [15:0]        feature_index;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic apply;
        logic copy;
        logic sum;
        logic div_go_l;
        logic cap_l;
        logic div_go_r;
        logic cap_r;
        logic gain;
        logic rec;
        logic emit_init;
        logic emit_rd;
        logic emit_ld;
        logic emit_next;
        logic end_run;
    } t_cmd;

    typedef struct packed {
        logic need_score;
        logic need_copy;
        logic sum_done;
        logic div_done;
        logic last;
        logic emit_final;
    } t_stat;

endpackage

### hw/rtl/gss_div.sv
// gss_div: restoring divider, one quotient bit per cycle
// shared by both side terms of a boundary score; uses no package items
module gss_div #(
    parameter int QW = 52
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [QW-1:0] i_dividend,
    input  logic [15:0]   i_divisor,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);
    localparam int CNTW = (QW > 1) ? $clog2(QW) : 1;

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [16:0]     r_rem;
    logic [QW-1:0]   r_q;
    logic [15:0]     r_div;
    logic [16:0]     n_rem_sh;
    logic            n_bit;

    always_comb begin
        n_rem_sh = {r_rem[15:0], r_q[QW-1]};
        n_bit    = (n_rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_go && !r_busy) begin
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_bit ? (n_rem_sh - {1'b0, r_div}) : n_rem_sh;
            r_q   <= {r_q[QW-2:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### hw/rtl/gss_dp.sv
// gss_dp: datapath of the gini split search
// class counters, run state, sum of squares, gain, best list and result register
// depends on gss_pkg and gss_div
module gss_dp
    import gss_pkg::*;
#(
    parameter int NUM_CLASSES      = 16,
    parameter int MAX_BEST_ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_cmd          i_cmd,
    output t_stat         o_stat,
    input  logic          i_op,
    input  logic [4:0]    i_class_label,
    input  logic [15:0]   i_class_total,
    input  logic [31:0]   i_sample_x,
    input  logic          i_last,
    output logic          o_has_split,
    output logic [3:0]    o_slot,
    output logic [31:0]   o_split_value,
    output logic [15:0]   o_best_feature,
    output logic [39:0]   o_best_gain,
    output logic [4:0]    o_num_best,
    output logic          o_final_res
);
    localparam int CW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CIW  = $clog2(NUM_CLASSES + 2);
    localparam int SW   = 32 + CW;
    localparam int QW   = SW + 16;
    localparam int GW   = QW + 3;
    localparam int MAW  = (MAX_BEST_ENTRIES > 1) ? $clog2(MAX_BEST_ENTRIES) : 1;
    localparam int NCW  = $clog2(MAX_BEST_ENTRIES + 1);

    // latched item
    logic [4:0]  r_cls;
    logic [31:0] r_x;
    logic        r_last;

    // run state
    logic        r_started;
    logic        r_mixed;
    logic [31:0] r_prev_x;
    logic [4:0]  r_prev_label;
    logic [15:0] r_pending;
    logic [15:0] r_sample_index;
    logic [15:0] r_left  [NUM_CLASSES];
    logic [15:0] r_right [NUM_CLASSES];
    logic [15:0] r_def_split;
    logic [31:0] r_def_mid;
    logic [15:0] r_def_l [NUM_CLASSES];
    logic [15:0] r_def_r [NUM_CLASSES];
    logic signed [39:0] r_cur_best;
    logic [4:0]  r_best_count;
    logic [NCW-1:0] r_new_count;
    logic [31:0] r_mem [MAX_BEST_ENTRIES];

    // scoring
    logic           r_use_def;
    logic [15:0]    r_nl;
    logic [31:0]    r_mid;
    logic [CIW-1:0] r_ci;
    logic [31:0]    r_sq_l, r_sq_r;
    logic [SW-1:0]  r_acc_l, r_acc_r;
    logic [QW-1:0]  r_ql, r_qr;
    logic signed [39:0] r_g;

    // emission
    logic [NCW-1:0] r_k;
    logic [31:0]    r_mid_rd;
    logic           r_has, r_final;
    logic [3:0]     r_slot;
    logic [31:0]    r_split;
    logic [15:0]    r_feat;
    logic [39:0]    r_gain_o;
    logic [4:0]     r_num_o;

    logic           n_eq, n_same, n_cls_ok, n_prev_ok;
    logic [CW-1:0]  n_cidx, n_pidx, n_sidx;
    logic signed [32:0] n_msum;
    logic [31:0]    n_mid;
    logic [15:0]    n_v_l, n_v_r;
    logic [15:0]    n_nr;
    logic           n_div_go;
    logic [QW-1:0]  n_dividend;
    logic [15:0]    n_divisor;
    logic           n_div_done;
    logic [QW-1:0]  n_quot;
    logic signed [GW-1:0] n_t_l, n_t_r, n_g_full;
    logic signed [39:0]   n_g_sat;
    logic [7:0]     n_slot_w;

    always_comb begin
        n_eq      = (r_x == r_prev_x);
        n_same    = (r_cls == r_prev_label);
        n_cls_ok  = (32'(i_class_label - 5'd1) < NUM_CLASSES);
        n_cidx    = CW'(5'(i_class_label - 5'd1));
        n_prev_ok = (32'(r_prev_label) < NUM_CLASSES);
        n_pidx    = CW'(r_prev_label);
        n_sidx    = r_ci[CW-1:0];
        n_msum    = {r_x[31], r_x} + {r_prev_x[31], r_prev_x};
        n_mid     = n_msum[32:1];
        n_nr      = (i_cfg.sample_count > r_nl) ? (i_cfg.sample_count - r_nl) : 16'd0;
        if (r_ci < CIW'(NUM_CLASSES)) begin
            n_v_l = r_use_def ? r_def_l[n_sidx] : r_left[n_sidx];
            n_v_r = r_use_def ? r_def_r[n_sidx] : r_right[n_sidx];
        end else begin
            n_v_l = '0;
            n_v_r = '0;
        end
    end

    assign o_stat.need_score = r_started &&
        ((n_eq && !n_same && !r_mixed && (r_def_split != 16'd0)) ||
         (!n_eq && !(n_same && !r_mixed)));
    assign o_stat.need_copy  = r_started && !n_eq && n_same && !r_mixed;
    assign o_stat.sum_done   = (r_ci == CIW'(NUM_CLASSES + 1));
    assign o_stat.div_done   = n_div_done;
    assign o_stat.last       = r_last;
    assign o_stat.emit_final = r_final;

    assign n_div_go   = i_cmd.div_go_l || i_cmd.div_go_r;
    assign n_dividend = i_cmd.div_go_r ? {r_acc_r, 16'h0} : {r_acc_l, 16'h0};
    assign n_divisor  = i_cmd.div_go_r ? n_nr : r_nl;

    gss_div #(.QW(QW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (n_div_go),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (n_div_done),
        .o_quot     (n_quot)
    );

    // side terms and saturated gain
    always_comb begin
        n_t_l    = (r_nl == 16'd0) ? '0 : (GW'({r_nl, 16'h0}) - GW'(r_ql));
        n_t_r    = (n_nr == 16'd0) ? '0 : (GW'({n_nr, 16'h0}) - GW'(r_qr));
        n_g_full = GW'(i_cfg.parent_impurity) - n_t_l - n_t_r;
        if (n_g_full > GW'(GAIN_MAX)) begin
            n_g_sat = GAIN_MAX;
        end else if (n_g_full < GW'(GAIN_MIN)) begin
            n_g_sat = GAIN_MIN;
        end else begin
            n_g_sat = n_g_full[39:0];
        end
        n_slot_w = 8'(r_best_count) - 8'(r_new_count) + 8'(r_k);
    end

    // control state of the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started      <= 1'b0;
            r_mixed        <= 1'b0;
            r_prev_x       <= '0;
            r_prev_label   <= '0;
            r_pending      <= '0;
            r_sample_index <= '0;
            r_def_split    <= '0;
            r_def_mid      <= '0;
            r_cur_best     <= '0;
            r_best_count   <= '0;
            r_new_count    <= '0;
            r_ci           <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_left[i]  <= '0;
                r_right[i] <= '0;
            end
        end else begin
            if (i_cmd.latch && !i_op && n_cls_ok) begin
                r_right[n_cidx] <= i_class_total;
            end
            if (i_cmd.apply) begin
                r_ci <= '0;
                if (!r_started) begin
                    r_started    <= 1'b1;
                    r_cur_best   <= i_cfg.start_best_gain;
                    r_best_count <= i_cfg.start_num_best;
                    r_new_count  <= '0;
                    r_mixed      <= 1'b0;
                    r_def_split  <= '0;
                    r_prev_x     <= r_x;
                    r_prev_label <= r_cls;
                    r_pending    <= 16'd1;
                end else if (n_eq && n_same) begin
                    r_pending <= r_pending + 16'd1;
                end else begin
                    if (n_prev_ok) begin
                        r_left[n_pidx]  <= r_left[n_pidx] + r_pending;
                        r_right[n_pidx] <= r_right[n_pidx] - r_pending;
                    end
                    r_pending    <= 16'd1;
                    r_prev_label <= r_cls;
                    if (n_eq) begin
                        if (!r_mixed) begin
                            r_mixed     <= 1'b1;
                            r_def_split <= '0;
                        end
                    end else begin
                        r_mixed  <= 1'b0;
                        r_prev_x <= r_x;
                        if (n_same && !r_mixed) begin
                            r_def_split <= r_sample_index;
                            r_def_mid   <= n_mid;
                        end else begin
                            r_def_split <= '0;
                        end
                    end
                end
                if (r_sample_index != 16'hFFFF) begin
                    r_sample_index <= r_sample_index + 16'd1;
                end
            end
            if (i_cmd.sum && (r_ci != CIW'(NUM_CLASSES + 1))) begin
                r_ci <= r_ci + 1'b1;
            end
            if (i_cmd.rec) begin
                if (r_g > r_cur_best) begin
                    r_cur_best   <= r_g;
                    r_best_count <= 5'd1;
                    r_new_count  <= NCW'(1);
                end else if ((r_g == r_cur_best) && (r_g > 40'sd0) &&
                             (r_best_count < i_cfg.max_best) &&
                             (32'(r_best_count) < MAX_BEST_ENTRIES) &&
                             (32'(r_new_count) < MAX_BEST_ENTRIES)) begin
                    r_new_count  <= r_new_count + 1'b1;
                    r_best_count <= r_best_count + 5'd1;
                end
            end
            if (i_cmd.end_run) begin
                r_started      <= 1'b0;
                r_mixed        <= 1'b0;
                r_prev_x       <= '0;
                r_prev_label   <= '0;
                r_pending      <= '0;
                r_sample_index <= '0;
                r_def_split    <= '0;
                for (int i = 0; i < NUM_CLASSES; i++) begin
                    r_left[i]  <= '0;
                    r_right[i] <= '0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cls  <= 5'(i_class_label - 5'd1);
            r_x    <= i_sample_x;
            r_last <= i_last;
        end
        if (i_cmd.apply) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
            if (n_eq) begin
                r_use_def <= 1'b1;
                r_nl      <= r_def_split;
                r_mid     <= r_def_mid;
            end else begin
                r_use_def <= 1'b0;
                r_nl      <= r_sample_index;
                r_mid     <= n_mid;
            end
        end
        if (i_cmd.copy) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_def_l[i] <= r_left[i];
                r_def_r[i] <= r_right[i];
            end
        end
        if (i_cmd.sum && (r_ci != CIW'(NUM_CLASSES + 1))) begin
            r_sq_l <= n_v_l * n_v_l;
            r_sq_r <= n_v_r * n_v_r;
            if (r_ci != '0) begin
                r_acc_l <= r_acc_l + SW'(r_sq_l);
                r_acc_r <= r_acc_r + SW'(r_sq_r);
            end
        end
        if (i_cmd.cap_l) begin
            r_ql <= n_quot;
        end
        if (i_cmd.cap_r) begin
            r_qr <= n_quot;
        end
        if (i_cmd.gain) begin
            r_g <= n_g_sat;
        end
    end

    // best midpoint memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rec) begin
            if (r_g > r_cur_best) begin
                r_mem[0] <= r_mid;
            end else if ((r_g == r_cur_best) && (r_g > 40'sd0) &&
                         (r_best_count < i_cfg.max_best) &&
                         (32'(r_best_count) < MAX_BEST_ENTRIES) &&
                         (32'(r_new_count) < MAX_BEST_ENTRIES)) begin
                r_mem[r_new_count[MAW-1:0]] <= r_mid;
            end
        end
        if (i_cmd.emit_rd) begin
            r_mid_rd <= r_mem[r_k[MAW-1:0]];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_final <= 1'b0;
        end else begin
            if (i_cmd.emit_init) begin
                r_k <= '0;
            end else if (i_cmd.emit_next) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.emit_ld) begin
                r_final <= (r_new_count == '0) || (r_k + 1'b1 == r_new_count);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ld) begin
            r_has    <= (r_new_count != '0);
            r_slot   <= (r_new_count != '0) ? n_slot_w[3:0] : 4'd0;
            r_split  <= (r_new_count != '0) ? r_mid_rd : 32'd0;
            r_feat   <= (r_new_count != '0) ? i_cfg.feature_index : 16'd0;
            r_gain_o <= r_cur_best;
            r_num_o  <= r_best_count;
        end
    end

    assign o_has_split    = r_has;
    assign o_slot         = r_slot;
    assign o_split_value  = r_split;
    assign o_best_feature = r_feat;
    assign o_best_gain    = r_gain_o;
    assign o_num_best     = r_num_o;
    assign o_final_res    = r_final;

    a_new_le_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> (5'(r_new_count) <= r_best_count || r_new_count == '0))
        else $error("new entries exceed best list count");

    a_sum_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sum && o_stat.sum_done) |=> o_stat.sum_done)
        else $error("sum counter ran past its end");

    a_div_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_go_l |-> !i_cmd.div_go_r)
        else $error("both divider starts in one cycle");

endmodule

### hw/rtl/gss_ctrl.sv
// gss_ctrl: sequencing state machine of the gini split search
// drives datapath commands and both stream handshakes; depends on gss_pkg
module gss_ctrl
    import gss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_op,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_APPLY = 4'd1;
    localparam logic [3:0] S_COPY  = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_DIVL  = 4'd4;
    localparam logic [3:0] S_DIVR  = 4'd5;
    localparam logic [3:0] S_GAIN  = 4'd6;
    localparam logic [3:0] S_REC   = 4'd7;
    localparam logic [3:0] S_CHKL  = 4'd8;
    localparam logic [3:0] S_EMRD  = 4'd9;
    localparam logic [3:0] S_EMLD  = 4'd10;
    localparam logic [3:0] S_EMWT  = 4'd11;

    logic [3:0] r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMWT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    if (i_in_op) begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                if (i_stat.need_copy) begin
                    n_state = S_COPY;
                end else if (i_stat.need_score) begin
                    n_state = S_SUM;
                end else begin
                    n_state = S_CHKL;
                end
            end
            S_COPY: begin
                o_cmd.copy = 1'b1;
                n_state    = S_CHKL;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                if (i_stat.sum_done) begin
                    o_cmd.div_go_l = 1'b1;
                    n_state        = S_DIVL;
                end
            end
            S_DIVL: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_l    = 1'b1;
                    o_cmd.div_go_r = 1'b1;
                    n_state        = S_DIVR;
                end
            end
            S_DIVR: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_r = 1'b1;
                    n_state     = S_GAIN;
                end
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = S_REC;
            end
            S_REC: begin
                o_cmd.rec = 1'b1;
                n_state   = S_CHKL;
            end
            S_CHKL: begin
                o_cmd.emit_init = 1'b1;
                n_state         = i_stat.last ? S_EMRD : S_IDLE;
            end
            S_EMRD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_EMLD;
            end
            S_EMLD: begin
                o_cmd.emit_ld = 1'b1;
                n_state       = S_EMWT;
            end
            S_EMWT: begin
                if (i_out_ready) begin
                    if (i_stat.emit_final) begin
                        o_cmd.end_run = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state         = S_EMRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result is shown");

    a_final_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_stat.emit_final) |=> o_in_ready)
        else $error("no return to idle after the final beat");

    a_div_done_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_DIVL || r_state == S_DIVR))
        else $error("divider finished outside a divide state");

endmodule

### hw/rtl/gini_split_search.sv
// gini_split_search: top level, configuration registers and stream ports
// instantiates gss_ctrl and gss_dp; depends on gss_pkg
//
// usage: write the registers over the apb port while the block is idle, then
// send beats on the slave stream. tuser 0 loads one class total, tuser 1 is
// a sample; samples arrive sorted by feature value and tlast marks the last
// one of the node. after the last sample the master stream returns one beat
// per newly recorded best split (or one beat with tuser 0 when there is
// none); tlast marks the final beat.
// a total is stored while the block stays idle; a sample that needs no score
// passes the apply, optional copy and last-check states; a scored boundary
// adds the class sum, two passes of the one-bit-per-cycle divider (left side,
// then right side), gain and record; each result beat passes the read, load
// and wait states and holds while the receiver stalls.
// one item is in work at a time; s_axis_tready is high only when idle.
// reset clears the run state, counters and best list control; registers
// return to their reset values. a stalled master side simply holds its beat.
module gini_split_search
    import gss_pkg::*;
#(
    parameter int NUM_CLASSES      = 16,
    parameter int MAX_BEST_ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // apb configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // input beats
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,  // class_label[4:0], class_total[20:5], sample_x[52:21]
    input  logic         s_axis_tuser,  // op
    input  logic         s_axis_tlast,  // last
    // result beats
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // slot[3:0], split_value[35:4], best_feature[51:36],
                                        // best_gain[91:52], num_best[96:92]
    output logic         m_axis_tuser,  // has_split
    output logic         m_axis_tlast   // final_res
);
    t_cfg  r_cfg;
    t_cmd  n_cmd;
    t_stat n_stat;

    logic        n_has;
    logic [3:0]  n_slot;
    logic [31:0] n_split;
    logic [15:0] n_feat;
    logic [39:0] n_gain;
    logic [4:0]  n_num;
    logic        n_final;

    assign pready = 1'b1;

    // register file, written on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_count    <= 16'd2;
            r_cfg.parent_impurity <= '0;
            r_cfg.start_best_gain <= '0;
            r_cfg.start_num_best  <= '0;
            r_cfg.max_best        <= 5'd16;
            r_cfg.feature_index   <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[5:3])
                REG_SAMPLE_COUNT:    r_cfg.sample_count    <= pwdata[15:0];
                REG_PARENT_IMPURITY: r_cfg.parent_impurity <= pwdata[31:0];
                REG_START_BEST_GAIN: r_cfg.start_best_gain <= pwdata[39:0];
                REG_START_NUM_BEST:  r_cfg.start_num_best  <= pwdata[4:0];
                REG_MAX_BEST:        r_cfg.max_best        <= pwdata[4:0];
                REG_FEATURE_INDEX:   r_cfg.feature_index   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_SAMPLE_COUNT:    prdata = 64'(r_cfg.sample_count);
            REG_PARENT_IMPURITY: prdata = 64'(r_cfg.parent_impurity);
            REG_START_BEST_GAIN: prdata = 64'(unsigned'(r_cfg.start_best_gain));
            REG_START_NUM_BEST:  prdata = 64'(r_cfg.start_num_best);
            REG_MAX_BEST:        prdata = 64'(r_cfg.max_best);
            REG_FEATURE_INDEX:   prdata = 64'(r_cfg.feature_index);
            default:             prdata = '0;
        endcase
    end

    // sequencer
    gss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (n_stat),
        .o_cmd       (n_cmd)
    );

    // counters, scoring and best list
    gss_dp #(
        .NUM_CLASSES      (NUM_CLASSES),
        .MAX_BEST_ENTRIES (MAX_BEST_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd          (n_cmd),
        .o_stat         (n_stat),
        .i_op           (s_axis_tuser),
        .i_class_label  (s_axis_tdata[4:0]),
        .i_class_total  (s_axis_tdata[20:5]),
        .i_sample_x     (s_axis_tdata[52:21]),
        .i_last         (s_axis_tlast),
        .o_has_split    (n_has),
        .o_slot         (n_slot),
        .o_split_value  (n_split),
        .o_best_feature (n_feat),
        .o_best_gain    (n_gain),
        .o_num_best     (n_num),
        .o_final_res    (n_final)
    );

    // result beat packing
    assign m_axis_tdata = {7'd0, n_num, n_gain, n_feat, n_split, n_slot};
    assign m_axis_tuser = n_has;
    assign m_axis_tlast = n_final;

endmodule
